// File: sv/tpa_pkg.sv
// Package for the tilt posture alert block: register map, event codes,
// configuration, state and result structs. No dependencies.
`default_nettype none

package tpa_pkg;

  localparam int unsigned AngleW = 12;
  localparam int unsigned MsW    = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CntW   = 16;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_ONSET     = 3'd1,
    REG_WINDOW    = 3'd2,
    REG_CONTINUED = 3'd3,
    REG_CONFIRM   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_SLOUCH    = 2'd1,
    EV_CONTINUED = 2'd2,
    EV_CORRECTED = 2'd3
  } event_t;

  localparam logic signed [AngleW-1:0] RstThreshold = 12'sd1120;
  localparam logic [MsW-1:0] RstOnset     = 16'd5000;
  localparam logic [MsW-1:0] RstWindow    = 16'd3000;
  localparam logic [MsW-1:0] RstContinued = 16'd20000;
  localparam logic [MsW-1:0] RstConfirm   = 16'd3000;
  localparam logic [CntW-1:0] CntMax      = '1;

  typedef struct packed {
    logic signed [AngleW-1:0] threshold;
    logic [MsW-1:0]           onset;
    logic [MsW-1:0]           window;
    logic [MsW-1:0]           continued;
    logic [MsW-1:0]           confirm;
  } cfg_t;

  typedef struct packed {
    logic             posture_ok;
    logic [TimeW-1:0] bad_since;
    logic             alert_sent;
    logic             confirming;
    logic [TimeW-1:0] confirm_since;
    logic             buzz_level;
    logic [CntW-1:0]  slouch_count;
  } state_t;

  typedef struct packed {
    logic                     buzzer_on;
    event_t                   event_code;
    logic signed [AngleW-1:0] event_angle;
    logic [CntW-1:0]          slouch_total;
  } result_t;

endpackage

`default_nettype wire

// File: sv/tpa_cfg.sv
// APB-style configuration registers for the tilt posture alert block.
// Depends on tpa_pkg.
`default_nettype none

module tpa_cfg
  import tpa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [DataW-1:0]  pwdata,
  output logic      [DataW-1:0]  prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_THRESHOLD: cfg_nxt.threshold = signed'(pwdata[AngleW-1:0]);
        REG_ONSET:     cfg_nxt.onset     = pwdata[MsW-1:0];
        REG_WINDOW:    cfg_nxt.window    = pwdata[MsW-1:0];
        REG_CONTINUED: cfg_nxt.continued = pwdata[MsW-1:0];
        REG_CONFIRM:   cfg_nxt.confirm   = pwdata[MsW-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THRESHOLD: prdata = DataW'(signed'(cfg_r.threshold));
      REG_ONSET:     prdata = DataW'(cfg_r.onset);
      REG_WINDOW:    prdata = DataW'(cfg_r.window);
      REG_CONTINUED: prdata = DataW'(cfg_r.continued);
      REG_CONFIRM:   prdata = DataW'(cfg_r.confirm);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= RstThreshold;
      cfg_r.onset     <= RstOnset;
      cfg_r.window    <= RstWindow;
      cfg_r.continued <= RstContinued;
      cfg_r.confirm   <= RstConfirm;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/tpa_step.sv
// Per-sample posture decision: next state and result from one sample.
// Purely combinational; depends on tpa_pkg.
`default_nettype none

module tpa_step
  import tpa_pkg::*;
(
  input  cfg_t                          cfg,
  input  state_t                        st,
  input  wire logic signed [AngleW-1:0] angle,
  input  wire logic [TimeW-1:0]         now,
  output state_t                        st_nxt,
  output result_t                       res
);

  logic             below;
  logic             above;
  logic [TimeW-1:0] elapsed;
  logic [MsW:0]     window_end;
  logic             in_window;
  logic             past_cont;
  logic [TimeW-1:0] confirm_base;
  logic             hold_met;
  event_t           ev;

  assign below        = angle < cfg.threshold;
  assign above        = angle > cfg.threshold;
  assign elapsed      = now - st.bad_since;
  assign window_end   = {1'b0, cfg.onset} + {1'b0, cfg.window};
  assign in_window    = (elapsed > TimeW'(cfg.onset)) && (elapsed < TimeW'(window_end));
  assign past_cont    = elapsed > TimeW'(cfg.continued);
  assign confirm_base = st.confirming ? st.confirm_since : now;
  assign hold_met     = (now - confirm_base) >= TimeW'(cfg.confirm);

  always_comb begin
    st_nxt = st;
    ev     = EV_NONE;
    if (below && st.posture_ok) begin
      st_nxt.posture_ok = 1'b0;
      st_nxt.bad_since  = now;
    end else if (below && in_window) begin
      st_nxt.buzz_level = 1'b1;
      if (!st.alert_sent) begin
        ev                = EV_SLOUCH;
        st_nxt.alert_sent = 1'b1;
        if (st.slouch_count != CntMax) begin
          st_nxt.slouch_count = st.slouch_count + CntW'(1);
        end
      end
    end else if (below && past_cont) begin
      st_nxt.buzz_level = 1'b1;
      st_nxt.confirming = 1'b0;
      if (!st.alert_sent) begin
        ev                = EV_CONTINUED;
        st_nxt.alert_sent = 1'b1;
      end
    end else if (above && !st.posture_ok) begin
      if (!st.confirming) begin
        st_nxt.confirm_since = now;
        st_nxt.confirming    = 1'b1;
        st_nxt.buzz_level    = 1'b0;
      end
      if (hold_met) begin
        st_nxt.posture_ok = 1'b1;
        st_nxt.confirming = 1'b0;
        st_nxt.alert_sent = 1'b0;
        ev                = EV_CORRECTED;
      end
    end else begin
      st_nxt.buzz_level = 1'b0;
      st_nxt.alert_sent = 1'b0;
    end
  end

  always_comb begin
    res.buzzer_on    = st_nxt.buzz_level;
    res.event_code   = ev;
    res.event_angle  = (ev != EV_NONE) ? angle : '0;
    res.slouch_total = st_nxt.slouch_count;
  end

endmodule

`default_nettype wire

// File: sv/tilt_posture_alert_fsm_unit.sv
// Top level of the tilt posture alert block: input register, state,
// result register. Depends on tpa_pkg, tpa_cfg and tpa_step.
//
//   channel | ports                                     | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid/in_ready, in_angle_z, in_now_ms  | sample in
//   out     | out_valid/out_ready, out_* result fields  | result out
//   cfg     | psel/penable/pwrite/paddr/pwdata/prdata   | APB regs
//
// One item per cycle unless out_ready stalls; input reg, then result reg.
// The posture state updates when the input register moves into the result
// register, so consecutive samples see each other's state with no bubble.
// A stalled result holds the input register; in_ready falls only when both
// are full. Synchronous active-low reset restores register defaults.
`default_nettype none

module tilt_posture_alert_fsm_unit
  import tpa_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [AngleW-1:0] in_angle_z,
  input  wire logic [TimeW-1:0]         in_now_ms,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_buzzer_on,
  output logic [1:0]                    out_event_code,
  output logic signed [AngleW-1:0]      out_event_angle,
  output logic [CntW-1:0]               out_slouch_total,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [AddrW-1:0]         paddr,
  input  wire logic [DataW-1:0]         pwdata,
  output logic [DataW-1:0]              prdata,
  output logic                          pready
);

  cfg_t                     cfg;
  state_t                   st_r;
  state_t                   st_nxt;
  result_t                  res;
  result_t                  res_r;
  logic                     s1_valid_r;
  logic signed [AngleW-1:0] s1_angle_r;
  logic [TimeW-1:0]         s1_now_r;
  logic                     out_valid_r;
  logic                     advance;

  tpa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpa_step u_step (
    .cfg    (cfg),
    .st     (st_r),
    .angle  (s1_angle_r),
    .now    (s1_now_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r.posture_ok    <= 1'b1;
      st_r.bad_since     <= '0;
      st_r.alert_sent    <= 1'b1;
      st_r.confirming    <= 1'b0;
      st_r.confirm_since <= '0;
      st_r.buzz_level    <= 1'b0;
      st_r.slouch_count  <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_angle_r <= in_angle_z;
      s1_now_r   <= in_now_ms;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_buzzer_on    = res_r.buzzer_on;
  assign out_event_code   = res_r.event_code;
  assign out_event_angle  = res_r.event_angle;
  assign out_slouch_total = res_r.slouch_total;

endmodule

`default_nettype wire
